// ----- src/psrg_pkg.sv -----
`timescale 1ns / 1ps

package psrg_pkg;

    // Accumulator is unsigned fixed point with FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 8;
    localparam int PWR_W     = 14;
    localparam int ACC_W     = PWR_W + FRAC_BITS;
    localparam int STEPS_W   = 17;
    localparam int CNT_W     = $clog2(ACC_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [PWR_W-1:0] POWER_MAX      = PWR_W'(9999);
    localparam logic [STEPS_W-1:0] STEPS_RESET  = STEPS_W'(1000 / 100);
    localparam logic [ACC_W:0] HALF_LSB         = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_SETPOINT = 2'd1;
    localparam logic [1:0] MODE_ON       = 2'd2;
    localparam logic [1:0] MODE_OFF      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP_STEPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN_STEPS = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [PWR_W-1:0] setpoint;
    } in_t;

    typedef struct packed {
        logic [PWR_W-1:0] forward_power;
        logic             output_on;
        logic             ramp_active;
    } out_t;

    // Round half up to whole watts.
    function automatic logic [PWR_W-1:0] round_pwr(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + HALF_LSB;
        return sum[FRAC_BITS +: PWR_W];
    endfunction

endpackage

// ----- src/psrg_div.sv -----
`timescale 1ns / 1ps

module psrg_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [psrg_pkg::ACC_W-1:0]      dividend,
    input  logic [psrg_pkg::STEPS_W-1:0]    divisor,
    output logic                            done,
    output logic [psrg_pkg::ACC_W-1:0]      quotient
);
    import psrg_pkg::*;

    // Restoring divider: one quotient bit per cycle, MSB first. The dividend
    // shifts out of the top of quo_reg while quotient bits shift in below.
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [STEPS_W-1:0]    rem_reg, rem_next;
    logic [ACC_W-1:0]      quo_reg, quo_next;
    logic [STEPS_W-1:0]    dvs_reg, dvs_next;
    logic [STEPS_W:0]      trial;
    logic [STEPS_W:0]      diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[ACC_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ACC_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[STEPS_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_next = trial[STEPS_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/power_setpoint_ramp_generator_unit.sv -----
`timescale 1ns / 1ps
// Path: a tick beat goes through EXEC and OUT, and through SNAP too while a ramp runs;
// a beat that starts a ramp goes through EXEC, DIV and OUT, waiting in DIV on the bit-serial divider.
// Throughput: one input beat at a time; the next beat is taken once the present one
// has reached the output register, even if that result is still waiting to be taken.
// Reset (aresetn low, synchronous): power, target, step and setpoint clear, output off,
// no ramp, ramp_enable 1 and both step counts 10.

module power_setpoint_ramp_generator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  psrg_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output psrg_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psrg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psrg_pkg::STEPS_W-1:0]      cfg_data
);
    import psrg_pkg::*;

    // Sequencer states. EXEC decodes the beat and does the work that needs no division,
    // DIV waits on the serial divider, SNAP ends a ramp once the rounded power
    // reaches the target, OUT hands the result to the output register.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SNAP = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    in_t                   in_reg, in_next;
    logic [ACC_W-1:0]      accum_reg, accum_next;
    logic [PWR_W-1:0]      target_reg, target_next;
    logic [ACC_W-1:0]      step_reg, step_next;
    logic [PWR_W-1:0]      stored_reg, stored_next;
    logic                  out_en_reg, out_en_next;
    logic                  ramping_reg, ramping_next;
    logic [PWR_W-1:0]      pend_tgt_reg, pend_tgt_next;
    logic                  dist_nz_reg, dist_nz_next;
    logic                  ramp_en_reg, ramp_en_next;
    logic [STEPS_W-1:0]    up_steps_reg, up_steps_next;
    logic [STEPS_W-1:0]    down_steps_reg, down_steps_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    // Decode of the beat held in in_reg.
    logic [PWR_W-1:0]      sp_sat;
    logic                  act;
    logic                  want_ramp;
    logic                  use_down;
    logic [PWR_W-1:0]      tgt;
    logic [ACC_W-1:0]      goal;
    logic                  going_up;
    logic [ACC_W-1:0]      span;
    logic [STEPS_W-1:0]    steps;
    logic                  div_start;
    logic                  div_done;
    logic [ACC_W-1:0]      div_quo;

    // Tick datapath.
    logic [ACC_W-1:0]      cur_goal;
    logic [ACC_W+1:0]      up_probe;
    logic [ACC_W+1:0]      down_limit;
    logic [PWR_W-1:0]      cur_round;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        sp_sat    = (in_reg.setpoint > POWER_MAX) ? POWER_MAX : in_reg.setpoint;
        act       = 1'b0;
        want_ramp = ramp_en_reg;
        use_down  = 1'b0;
        tgt       = '0;
        case (in_reg.mode)
            MODE_SETPOINT: begin
                // While the output is off the setpoint is only remembered.
                act = out_en_reg;
                tgt = sp_sat;
            end
            MODE_ON: begin
                act = 1'b1;
                tgt = stored_reg;
            end
            MODE_OFF: begin
                // Switching off at zero power cancels any ramp outright.
                act       = 1'b1;
                use_down  = 1'b1;
                want_ramp = ramp_en_reg && (accum_reg != '0);
            end
            default: begin
                act = 1'b0;
            end
        endcase
        goal     = {tgt, {FRAC_BITS{1'b0}}};
        going_up = (goal >= accum_reg);
        span     = going_up ? (goal - accum_reg) : (accum_reg - goal);
        steps    = (going_up && !use_down) ? up_steps_reg : down_steps_reg;
    end

    always_comb begin
        cur_goal   = {target_reg, {FRAC_BITS{1'b0}}};
        cur_round  = round_pwr(accum_reg);
        up_probe   = {2'b00, accum_reg} + {1'b0, step_reg, 1'b0};
        down_limit = {2'b00, cur_goal} + {1'b0, step_reg, 1'b0};
    end

    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        accum_next      = accum_reg;
        target_next     = target_reg;
        step_next       = step_reg;
        stored_next     = stored_reg;
        out_en_next     = out_en_reg;
        ramping_next    = ramping_reg;
        pend_tgt_next   = pend_tgt_reg;
        dist_nz_next    = dist_nz_reg;
        ramp_en_next    = ramp_en_reg;
        up_steps_next   = up_steps_reg;
        down_steps_next = down_steps_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        div_start       = 1'b0;

        // The user must write registers only while the block is idle; the block itself does not enforce this.
        if (cfg_valid) begin
            case (cfg_index)
                CFG_RAMP_ENABLE:     ramp_en_next    = cfg_data[0];
                CFG_RAMP_UP_STEPS:   up_steps_next   = cfg_data;
                CFG_RAMP_DOWN_STEPS: down_steps_next = cfg_data;
                default:             ramp_en_next    = ramp_en_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (in_reg.mode == MODE_TICK) begin
                    state_next = ST_OUT;
                    if (ramping_reg) begin
                        state_next = ST_SNAP;
                        // Move one step, or land on the goal when the step
                        // after this one would overshoot it.
                        if (cur_round != target_reg) begin
                            if (accum_reg < cur_goal) begin
                                if (up_probe > {2'b00, cur_goal}) begin
                                    accum_next = cur_goal;
                                end else begin
                                    accum_next = accum_reg + step_reg;
                                end
                            end else if (accum_reg > cur_goal) begin
                                if ({2'b00, accum_reg} < down_limit) begin
                                    accum_next = cur_goal;
                                end else begin
                                    accum_next = accum_reg - step_reg;
                                end
                            end
                        end
                    end
                end else begin
                    state_next = ST_OUT;
                    if (in_reg.mode == MODE_SETPOINT) begin
                        stored_next = sp_sat;
                    end
                    if (in_reg.mode == MODE_ON) begin
                        out_en_next = 1'b1;
                    end
                    if (in_reg.mode == MODE_OFF) begin
                        out_en_next = 1'b0;
                    end
                    if (act) begin
                        if (!want_ramp || steps == '0) begin
                            target_next  = tgt;
                            accum_next   = goal;
                            step_next    = '0;
                            ramping_next = 1'b0;
                        end else begin
                            div_start     = 1'b1;
                            pend_tgt_next = tgt;
                            dist_nz_next  = (span != '0);
                            state_next    = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    // A nonzero distance always gets at least one LSB of step.
                    step_next    = (div_quo == '0 && dist_nz_reg) ? ACC_W'(1) : div_quo;
                    target_next  = pend_tgt_reg;
                    ramping_next = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_SNAP: begin
                if (cur_round == target_reg) begin
                    accum_next   = cur_goal;
                    ramping_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.forward_power = cur_round;
                    m_data_next.output_on     = out_en_reg;
                    m_data_next.ramp_active   = ramping_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    psrg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (span),
        .divisor  (steps),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            accum_reg      <= '0;
            target_reg     <= '0;
            step_reg       <= '0;
            stored_reg     <= '0;
            out_en_reg     <= 1'b0;
            ramping_reg    <= 1'b0;
            ramp_en_reg    <= 1'b1;
            up_steps_reg   <= STEPS_RESET;
            down_steps_reg <= STEPS_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            accum_reg      <= accum_next;
            target_reg     <= target_next;
            step_reg       <= step_next;
            stored_reg     <= stored_next;
            out_en_reg     <= out_en_next;
            ramping_reg    <= ramping_next;
            ramp_en_reg    <= ramp_en_next;
            up_steps_reg   <= up_steps_next;
            down_steps_reg <= down_steps_next;
            m_valid_reg    <= m_valid_next;
        end
        in_reg       <= in_next;
        pend_tgt_reg <= pend_tgt_next;
        dist_nz_reg  <= dist_nz_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ----- src/psrg_checker.sv -----
`timescale 1ns / 1ps

module psrg_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  psrg_pkg::out_t                    m_data
);
    import psrg_pkg::*;

    // Beats taken in but not yet delivered.
    logic [1:0] pend_reg, pend_next;
    logic       s_beat;
    logic       m_beat;

    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (s_beat && !m_beat) begin
            pend_next = pend_reg + 1'b1;
        end else if (m_beat && !s_beat) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result beat without an input beat");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("more than two beats in flight");

    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.forward_power <= POWER_MAX)
        else $error("forward power out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind power_setpoint_ramp_generator_unit psrg_checker u_psrg_checker (.*);
